// File: hw/rtl/moving_average_to_pwm_duty_macros.svh
// Assertion helpers for the checker file
`ifndef MOVING_AVERAGE_TO_PWM_DUTY_MACROS_SVH
`define MOVING_AVERAGE_TO_PWM_DUTY_MACROS_SVH

// Same-cycle implication, disabled during reset
`define MAVGPWM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define MAVGPWM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/mavgpwm_pkg.sv
`default_nettype none
package mavgpwm_pkg;

   localparam int WINDOW_DEF      = 8;
   localparam int SAMPLE_BITS_DEF = 12;

   localparam int SAMPLE_W  = 12;
   localparam int AVG_OUT_W = 12;
   localparam int THR_W     = 12;
   localparam int DUTY_W    = 16;
   localparam int SPAN_W    = THR_W;
   localparam int PROD_W    = SPAN_W + DUTY_W;
   // Dividend width covers both the scaled product and the largest running sum
   localparam int DVD_W     = PROD_W;
   localparam int STEP_W    = $clog2(DVD_W + 1);

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_LOW_THRESHOLD  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HIGH_THRESHOLD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FULL_DUTY      = 2'd2;

   localparam logic [THR_W-1:0]  LOW_THRESHOLD_RST  = 12'd1650;
   localparam logic [THR_W-1:0]  HIGH_THRESHOLD_RST = 12'd3950;
   localparam logic [DUTY_W-1:0] FULL_DUTY_RST      = 16'd999;

   typedef struct packed {
      logic              start;
      logic [STEP_W-1:0] steps;
      logic [DVD_W-1:0]  dividend;
      logic [SPAN_W-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic             done;
      logic [DVD_W-1:0] quotient;
   } div_sts_type;

endpackage
`default_nettype wire

// File: hw/rtl/moving_average_to_pwm_duty.sv
// Flow: an accepted sample updates the running sum, the shared restoring divider forms the
//   average, and an average between the thresholds is scaled by a second division.
// A new sample is taken only after the previous result has been accepted; the divider
//   produces one quotient bit per cycle while it is busy.
// Reset (synchronous, active high) clears the running sum, write position and fill count,
//   and loads the threshold and full duty registers with their defaults.
`default_nettype none
module moving_average_to_pwm_duty #(
   parameter int WINDOW      = mavgpwm_pkg::WINDOW_DEF,
   parameter int SAMPLE_BITS = mavgpwm_pkg::SAMPLE_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // [11:0] sample
   input  wire logic [mavgpwm_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [15:0] duty, [27:16] average
   output logic      [mavgpwm_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [mavgpwm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [mavgpwm_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import mavgpwm_pkg::*;

   localparam int POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W = $clog2(WINDOW + 1);
   localparam int AVG_W = SAMPLE_BITS;
   localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW);
   localparam int CMP_W = (AVG_W > THR_W) ? AVG_W : THR_W;

   typedef enum logic [6:0] {
      ST_IDLE       = 7'b0000001,
      ST_UPDATE     = 7'b0000010,
      ST_AVG_GO     = 7'b0000100,
      ST_AVG_WAIT   = 7'b0001000,
      ST_MAP        = 7'b0010000,
      ST_SCALE_GO   = 7'b0100000,
      ST_SCALE_WAIT = 7'b1000000
   } state_type;

   // Result hold is tracked apart from the sequencer state
   state_type               state_ff, state_in;
   logic                    hold_ff, hold_in;
   logic [THR_W-1:0]        low_ff, low_in;
   logic [THR_W-1:0]        high_ff, high_in;
   logic [DUTY_W-1:0]       full_ff, full_in;
   logic [SAMPLE_BITS-1:0]  sample_ff, sample_in;
   logic [SUM_W-1:0]        sum_ff, sum_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic [CNT_W-1:0]        fill_ff, fill_in;
   logic [AVG_W-1:0]        avg_ff, avg_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic [DUTY_W-1:0]       duty_ff, duty_in;

   logic [SAMPLE_BITS-1:0]  ring_rd;
   logic [SAMPLE_BITS-1:0]  oldest;
   logic [15:0]             sample_wide;
   logic                    ring_full;
   logic                    req_xfer;
   logic                    rsp_xfer;
   logic [CMP_W-1:0]        avg_cmp, low_cmp, high_cmp, diff_cmp;
   logic [SPAN_W-1:0]       diff;
   logic [SPAN_W-1:0]       span;
   div_cmd_type             div_cmd;
   div_sts_type             div_sts;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE) && !hold_ff;
   assign rsp_tvalid = hold_ff;
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_xfer   = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = RSP_DATA_W'({AVG_OUT_W'(avg_ff), duty_ff});

   assign sample_wide = 16'(req_tdata[SAMPLE_W-1:0]);
   assign ring_full   = fill_ff == CNT_W'(WINDOW);
   // Slots ahead of the fill count were never written and read as zero
   assign oldest      = ring_full ? ring_rd : '0;

   assign avg_cmp  = CMP_W'(avg_ff);
   assign low_cmp  = CMP_W'(low_ff);
   assign high_cmp = CMP_W'(high_ff);
   assign diff_cmp = avg_cmp - low_cmp;
   assign diff     = diff_cmp[SPAN_W-1:0];
   assign span     = high_ff - low_ff;

   mavgpwm_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (WINDOW),
      .ADDR_W(POS_W)
   ) u_ring (
      .clock  (clock),
      .wr_en  (state_ff == ST_UPDATE),
      .wr_addr(pos_ff),
      .wr_data(sample_ff),
      .rd_addr(pos_ff),
      .rd_data(ring_rd)
   );

   mavgpwm_div u_div (
      .clock(clock),
      .reset(reset),
      .cmd  (div_cmd),
      .sts  (div_sts)
   );

   always_comb begin
      div_cmd = '0;
      unique case (state_ff)
         ST_AVG_GO: begin
            div_cmd.start    = 1'b1;
            div_cmd.steps    = STEP_W'(SUM_W);
            div_cmd.dividend = DVD_W'(sum_ff) << (DVD_W - SUM_W);
            div_cmd.divisor  = SPAN_W'(fill_ff);
         end
         ST_SCALE_GO: begin
            div_cmd.start    = 1'b1;
            div_cmd.steps    = STEP_W'(PROD_W);
            div_cmd.dividend = DVD_W'(prod_ff) << (DVD_W - PROD_W);
            div_cmd.divisor  = span;
         end
         default: begin
            div_cmd = '0;
         end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      hold_in   = hold_ff;
      low_in    = low_ff;
      high_in   = high_ff;
      full_in   = full_ff;
      sample_in = sample_ff;
      sum_in    = sum_ff;
      pos_in    = pos_ff;
      fill_in   = fill_ff;
      avg_in    = avg_ff;
      prod_in   = prod_ff;
      duty_in   = duty_ff;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_LOW_THRESHOLD:  low_in  = csr_wdata[THR_W-1:0];
            REG_HIGH_THRESHOLD: high_in = csr_wdata[THR_W-1:0];
            REG_FULL_DUTY:      full_in = csr_wdata[DUTY_W-1:0];
            default: begin
            end
         endcase
      end

      if (rsp_xfer) begin
         hold_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               sample_in = sample_wide[SAMPLE_BITS-1:0];
               state_in  = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            sum_in   = sum_ff - SUM_W'(oldest) + SUM_W'(sample_ff);
            pos_in   = (pos_ff == POS_W'(WINDOW - 1)) ? '0 : pos_ff + POS_W'(1);
            fill_in  = ring_full ? fill_ff : fill_ff + CNT_W'(1);
            state_in = ST_AVG_GO;
         end
         ST_AVG_GO: begin
            state_in = ST_AVG_WAIT;
         end
         ST_AVG_WAIT: begin
            if (div_sts.done) begin
               avg_in   = div_sts.quotient[AVG_W-1:0];
               state_in = ST_MAP;
            end
         end
         ST_MAP: begin
            priority if (avg_cmp <= low_cmp) begin
               duty_in  = '0;
               hold_in  = 1'b1;
               state_in = ST_IDLE;
            end else if (avg_cmp >= high_cmp) begin
               duty_in  = full_ff;
               hold_in  = 1'b1;
               state_in = ST_IDLE;
            end else begin
               prod_in  = PROD_W'(diff) * PROD_W'(full_ff);
               state_in = ST_SCALE_GO;
            end
         end
         ST_SCALE_GO: begin
            state_in = ST_SCALE_WAIT;
         end
         ST_SCALE_WAIT: begin
            if (div_sts.done) begin
               duty_in  = div_sts.quotient[DUTY_W-1:0];
               hold_in  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         hold_ff  <= 1'b0;
         low_ff   <= LOW_THRESHOLD_RST;
         high_ff  <= HIGH_THRESHOLD_RST;
         full_ff  <= FULL_DUTY_RST;
         sum_ff   <= '0;
         pos_ff   <= '0;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         hold_ff  <= hold_in;
         low_ff   <= low_in;
         high_ff  <= high_in;
         full_ff  <= full_in;
         sum_ff   <= sum_in;
         pos_ff   <= pos_in;
         fill_ff  <= fill_in;
      end
      sample_ff <= sample_in;
      avg_ff    <= avg_in;
      prod_ff   <= prod_in;
      duty_ff   <= duty_in;
   end

endmodule
`default_nettype wire

// File: hw/rtl/mavgpwm_ram.sv
`default_nettype none
module mavgpwm_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 8,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

// File: hw/rtl/mavgpwm_div.sv
`default_nettype none
module mavgpwm_div (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire mavgpwm_pkg::div_cmd_type  cmd,
   output mavgpwm_pkg::div_sts_type       sts
);
   import mavgpwm_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [SPAN_W-1:0] rem_ff, rem_in;
   logic [DVD_W-1:0]  quo_ff, quo_in;
   logic [SPAN_W-1:0] dvs_ff, dvs_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [SPAN_W:0]   shifted;
   logic [SPAN_W:0]   trial;
   logic              ge;

   assign shifted = {rem_ff, quo_ff[DVD_W-1]};
   assign ge      = shifted >= {1'b0, dvs_ff};
   assign trial   = shifted - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         rem_in  = '0;
         quo_in  = cmd.dividend;
         dvs_in  = cmd.divisor;
         cnt_in  = cmd.steps;
      end else if (busy_ff) begin
         rem_in = ge ? trial[SPAN_W-1:0] : shifted[SPAN_W-1:0];
         quo_in = {quo_ff[DVD_W-2:0], ge};
         cnt_in = cnt_ff - STEP_W'(1);
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign sts.done     = done_ff;
   assign sts.quotient = quo_ff;

endmodule
`default_nettype wire

// File: hw/rtl/mavgpwm_chk.sv
`default_nettype none
`include "moving_average_to_pwm_duty_macros.svh"
module mavgpwm_chk (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_tvalid,
   input wire logic                                req_tready,
   input wire logic                                rsp_tvalid,
   input wire logic                                rsp_tready,
   input wire logic [mavgpwm_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import mavgpwm_pkg::*;

   `MAVGPWM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result dropped or changed while stalled")
   `MAVGPWM_ASSERT_NEXT(a_busy_after_req, clock, reset, req_tvalid && req_tready, !req_tready, "new transfer taken while an item is in flight")
   `MAVGPWM_ASSERT_NEXT(a_no_instant_rsp, clock, reset, req_tvalid && req_tready, !rsp_tvalid, "result shown before the average is formed")
   `MAVGPWM_ASSERT_SAME(a_one_in_flight, clock, reset, rsp_tvalid, !req_tready, "input taken while a result waits")

endmodule

bind moving_average_to_pwm_duty mavgpwm_chk u_mavgpwm_chk (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);
`default_nettype wire
